// File: rtl/core/cda_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar functions for the calendar date adder.
package cda_pkg;

  localparam int YEAR_W          = 15;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int KIND_W          = 3;
  localparam int M400_W          = 9;
  localparam int MULT_W          = 10;
  localparam int AMOUNT_BITS_DEF = 12;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 15'h7FFF;
  localparam logic [YEAR_W-1:0]  YEAR_400  = 15'd400;
  localparam logic [M400_W-1:0]  M400_LAST = 9'd399;
  localparam logic [M400_W-1:0]  M400_100  = 9'd100;
  localparam logic [M400_W-1:0]  M400_200  = 9'd200;
  localparam logic [M400_W-1:0]  M400_300  = 9'd300;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

  localparam logic [MULT_W-1:0]  MULT_YEAR       = 10'd1;
  localparam logic [MULT_W-1:0]  MULT_DECADE     = 10'd10;
  localparam logic [MULT_W-1:0]  MULT_CENTURY    = 10'd100;
  localparam logic [MULT_W-1:0]  MULT_MILLENNIUM = 10'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_DAYS       = 3'd0,
    KIND_WEEKS      = 3'd1,
    KIND_MONTHS     = 3'd2,
    KIND_YEARS      = 3'd3,
    KIND_DECADES    = 3'd4,
    KIND_CENTURIES  = 3'd5,
    KIND_MILLENNIA  = 3'd6
  } kind_t;

  // Date plus the year reduced mod 400, which carries the leap rule.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [M400_W-1:0]  m400;
  } date_t;

  function automatic logic is_leap(input logic [M400_W-1:0] m400);
    return (m400 == '0) ||
           ((m400[1:0] == 2'b00) && (m400 != M400_100) &&
            (m400 != M400_200) && (m400 != M400_300));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/cda_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the date adder request and result.
interface cda_in_if #(
  parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [cda_pkg::KIND_W-1:0]  kind;
  logic [cda_pkg::YEAR_W-1:0]  start_year;
  logic [cda_pkg::MONTH_W-1:0] start_month;
  logic [cda_pkg::DAY_W-1:0]   start_day;
  logic [AMOUNT_BITS-1:0]      amount;

  modport source (output valid, kind, start_year, start_month, start_day, amount,
                  input ready);
  modport sink   (input valid, kind, start_year, start_month, start_day, amount,
                  output ready);
endinterface

interface cda_out_if;
  logic                        valid;
  logic                        ready;
  logic [cda_pkg::YEAR_W-1:0]  result_year;
  logic [cda_pkg::MONTH_W-1:0] result_month;
  logic [cda_pkg::DAY_W-1:0]   result_day;
  logic                        year_saturated;
  logic                        bad_input;

  modport source (output valid, result_year, result_month, result_day,
                  year_saturated, bad_input, input ready);
  modport sink   (input valid, result_year, result_month, result_day,
                  year_saturated, bad_input, output ready);
endinterface

// File: rtl/core/cda_step_unit.sv
`timescale 1ns / 1ps
// Single day or month step of a date with rollover, clamp and saturation.
module cda_step_unit (
  input  cda_pkg::date_t cur,
  input  logic           month_mode,
  output cda_pkg::date_t nxt,
  output logic           sat
);
  import cda_pkg::*;

  logic [DAY_W-1:0]  cur_len;
  logic [DAY_W-1:0]  new_len;
  date_t             adv;
  logic              adv_sat;

  assign cur_len = days_in(cur.month, is_leap(cur.m400));

  // month/year advance shared by both modes
  always_comb begin
    adv     = cur;
    adv_sat = 1'b0;
    if (cur.month < MONTH_DEC) begin
      adv.month = cur.month + 4'd1;
    end else if (cur.year < YEAR_MAX) begin
      adv.month = MONTH_JAN;
      adv.year  = cur.year + 15'd1;
      adv.m400  = (cur.m400 == M400_LAST) ? '0 : cur.m400 + 9'd1;
    end else begin
      adv_sat = 1'b1;
    end
  end

  assign new_len = days_in(adv.month, is_leap(adv.m400));

  always_comb begin
    nxt = cur;
    sat = 1'b0;
    if (month_mode) begin
      if (adv_sat) begin
        sat = 1'b1;
      end else begin
        nxt = adv;
        if (cur.day > new_len) begin
          nxt.day = new_len;
        end
      end
    end else if (cur.day < cur_len) begin
      nxt.day = cur.day + 5'd1;
    end else if (adv_sat) begin
      sat = 1'b1;
    end else begin
      nxt     = adv;
      nxt.day = DAY_FIRST;
    end
  end

endmodule

// File: rtl/core/calendar_date_adder.sv
`timescale 1ns / 1ps
// Calendar date adder top level: sequencer, year reduction, multiply-add and output register.
// Sequence: the year is reduced mod 400 by repeated subtraction and the date is checked, then
//   the step loop takes one step per day or month (seven per week), or a multiply and an add
//   serve the year kinds, and the result is then loaded into the output register.
// Input is ready only while idle, so a new transaction is taken only after the last one is done.
// Reset: synchronous active-low rst_n returns the sequencer to idle and drops out valid.
module calendar_date_adder #(
  parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  cda_in_if.sink        in_chan,
  cda_out_if.source     out_chan
);
  import cda_pkg::*;

  localparam int CNT_W  = AMOUNT_BITS + 3;
  localparam int PROD_W = AMOUNT_BITS + MULT_W;
  localparam int SUM_W  = ((YEAR_W > PROD_W) ? YEAR_W : PROD_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_STEP,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  state_t                 state_r;
  kind_t                  kind_r;
  logic [AMOUNT_BITS-1:0] amt_r;
  date_t                  cur_r;
  logic [YEAR_W-1:0]      red_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   month_mode_r;
  logic                   sat_r;
  logic                   bad_r;

  logic                   out_valid_r;
  logic [YEAR_W-1:0]      out_year_r;
  logic [MONTH_W-1:0]     out_month_r;
  logic [DAY_W-1:0]       out_day_r;
  logic                   out_sat_r;
  logic                   out_bad_r;

  date_t                  step_nxt;
  logic                   step_sat;
  logic                   date_bad;
  logic [MULT_W-1:0]      mult;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       amt_ext;

  cda_step_unit u_step (
    .cur        (cur_r),
    .month_mode (month_mode_r),
    .nxt        (step_nxt),
    .sat        (step_sat)
  );

  assign date_bad = (cur_r.month < MONTH_JAN) || (cur_r.month > MONTH_DEC) ||
                    (cur_r.day == '0) ||
                    (cur_r.day > days_in(cur_r.month, is_leap(cur_r.m400)));

  always_comb begin
    unique case (kind_r)
      KIND_DECADES:   mult = MULT_DECADE;
      KIND_CENTURIES: mult = MULT_CENTURY;
      KIND_MILLENNIA: mult = MULT_MILLENNIUM;
      default:        mult = MULT_YEAR;
    endcase
  end

  assign amt_ext = CNT_W'(amt_r);
  assign sum     = SUM_W'(cur_r.year) + SUM_W'(prod_r);

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_year   = out_year_r;
  assign out_chan.result_month  = out_month_r;
  assign out_chan.result_day    = out_day_r;
  assign out_chan.year_saturated = out_sat_r;
  assign out_chan.bad_input     = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            kind_r      <= kind_t'(in_chan.kind);
            amt_r       <= in_chan.amount;
            cur_r.year  <= in_chan.start_year;
            cur_r.month <= in_chan.start_month;
            cur_r.day   <= in_chan.start_day;
            red_r       <= in_chan.start_year;
            state_r     <= S_MOD;
          end
        end
        S_MOD: begin
          if (red_r >= YEAR_400) begin
            red_r <= red_r - YEAR_400;
          end else begin
            cur_r.m400 <= red_r[M400_W-1:0];
            state_r    <= S_CHECK;
          end
        end
        S_CHECK: begin
          sat_r        <= 1'b0;
          bad_r        <= date_bad;
          month_mode_r <= (kind_r == KIND_MONTHS);
          cnt_r        <= (kind_r == KIND_WEEKS) ? (amt_ext << 3) - amt_ext : amt_ext;
          if (date_bad) begin
            state_r <= S_DONE;
          end else begin
            unique case (kind_r)
              KIND_DAYS, KIND_WEEKS, KIND_MONTHS: state_r <= S_STEP;
              KIND_YEARS, KIND_DECADES, KIND_CENTURIES, KIND_MILLENNIA: state_r <= S_MUL;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_STEP: begin
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else if (step_sat) begin
            sat_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            cur_r <= step_nxt;
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(amt_r) * PROD_W'(mult);
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (sum > SUM_W'(YEAR_MAX)) begin
            cur_r.year <= YEAR_MAX;
            sat_r      <= 1'b1;
          end else begin
            cur_r.year <= sum[YEAR_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_year_r  <= cur_r.year;
            out_month_r <= cur_r.month;
            out_day_r   <= cur_r.day;
            out_sat_r   <= sat_r;
            out_bad_r   <= bad_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/cda_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the calendar date adder and their bind.
module cda_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cda_pkg::YEAR_W-1:0]  out_year,
  input logic [cda_pkg::MONTH_W-1:0] out_month,
  input logic [cda_pkg::DAY_W-1:0]   out_day,
  input logic                        out_sat,
  input logic                        out_bad
);
  import cda_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) &&
      $stable(out_month) && $stable(out_day) && $stable(out_sat) && $stable(out_bad))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> !out_sat)
    else $error("bad input and saturation both set");

  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad |-> out_month >= MONTH_JAN && out_month <= MONTH_DEC &&
      out_day != '0)
    else $error("result date out of range");

  a_sat_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |-> out_year == YEAR_MAX)
    else $error("saturated result below the year limit");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_year  (out_chan.result_year),
  .out_month (out_chan.result_month),
  .out_day   (out_chan.result_day),
  .out_sat   (out_chan.year_saturated),
  .out_bad   (out_chan.bad_input)
);
